/* rtl/core/gsl_pkg.sv */
// Shared types and constants for the gradient slope limiter core.
// No dependencies; compile first.
`default_nettype none

package gsl_pkg;

  localparam int DATA_W    = 32;
  localparam int BETA_W    = 17;
  localparam int QUO_W     = 17;
  localparam int MUL_STEPS = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [BETA_W-1:0] BETA_ONE  = 17'd65536;
  localparam logic [BETA_W-1:0] BETA_ZERO = 17'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_Y  = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] probe_x;
    logic signed [DATA_W-1:0] probe_y;
    logic signed [DATA_W-1:0] lower_bound;
    logic signed [DATA_W-1:0] upper_bound;
    logic                     last_probe;
  } probe_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] fit_value;
    logic [BETA_W-1:0]        limit_factor;
    logic                     final_res;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/gsl_if.sv */
// Valid/ready channel interfaces for probe items and limiter results.
// Depends on gsl_pkg.
`default_nettype none

interface gsl_probe_if
  import gsl_pkg::*;
();
  logic   valid;
  logic   ready;
  probe_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gsl_result_if
  import gsl_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/gradient_slope_limiter_core.sv */
// Gradient slope limiter core: evaluates a linear cell fit at probe points and
// lowers a running limit factor. Depends on gsl_pkg and gsl_if.sv.
//
// Each probe transfer on in_probe yields exactly one result transfer on
// out_result: the unlimited fit value at the probe (saturated Q16.16), the
// running limit factor beta after this probe (Q1.16, 65536 is one) and
// final_res, a copy of last_probe. After a result with final_res set, beta
// returns to one for the next cell. One probe is in flight at a time. The
// clamped offsets are formed in the transfer cycle itself; then come two
// radix-4 shift-add multipliers (slope times offset, two multiplier bits per
// cycle), a state to sum the slope term, one to set up the divisions, two
// radix-2 restoring dividers (one quotient bit per cycle, one per bound) and
// a state to fold the quotients into beta. The input side opens again as the
// result enters the output register, so a new probe is taken only once the
// last one's result is registered, and a waiting result only stalls the core
// if it is still untaken when the next one finishes. Configuration registers
// are written through cfg_wr_en, cfg_index and cfg_wdata and must only change
// while the core is idle.
`default_nettype none

module gradient_slope_limiter_core
  import gsl_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  gsl_probe_if.sink            in_probe,
  gsl_result_if.source         out_result,
  input  wire                  cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [DATA_W-1:0]     cfg_wdata
);

  // magnitude of the slope term, signed slope term, fit value
  localparam int MAG_W = 2 * DATA_W - FRAC_BITS;
  localparam int D_W   = MAG_W + 1;
  localparam int Z_W   = D_W + 1;
  localparam int PRD_W = 2 * DATA_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  // control
  logic [2:0]              state_r, state_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic [BETA_W-1:0]       beta_r, beta_nxt;
  logic                    out_valid_r, out_valid_nxt;
  result_t                 out_data_r, out_data_nxt;

  // configuration
  logic signed [DATA_W-1:0] cx_r, cy_r, mean_r, sx_r, sy_r;

  // probe hold
  logic signed [DATA_W-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic                     last_r, last_nxt;

  // multiplier lanes: 0 is x, 1 is y
  logic [DATA_W-1:0]       mcand_r [2];
  logic [DATA_W-1:0]       mcand_nxt [2];
  logic [PRD_W-1:0]        prod_r [2];
  logic [PRD_W-1:0]        prod_nxt [2];
  logic                    psign_r [2];
  logic                    psign_nxt [2];

  // slope term and fit
  logic signed [D_W-1:0]   d_r, d_nxt;
  logic signed [Z_W-1:0]   z_r, z_nxt;
  logic [MAG_W-1:0]        dmag_r, dmag_nxt;
  logic                    dnz_r, dnz_nxt;

  // divider lanes: 0 is the upper bound, 1 is the lower bound
  logic                    apply_r [2];
  logic                    apply_nxt [2];
  logic                    zero_r [2];
  logic                    zero_nxt [2];
  logic                    ovf_r [2];
  logic                    ovf_nxt [2];
  logic [MAG_W-1:0]        rem_r [2];
  logic [MAG_W-1:0]        rem_nxt [2];
  logic [QUO_W-1:0]        sh_r [2];
  logic [QUO_W-1:0]        sh_nxt [2];
  logic [QUO_W-1:0]        quo_r [2];
  logic [QUO_W-1:0]        quo_nxt [2];

  // combinational helpers
  logic signed [DATA_W:0]   dx_wide, dy_wide;
  logic [DATA_W-1:0]        off_sat [2];
  logic [DATA_W-1:0]        off_mag [2];
  logic [DATA_W-1:0]        slope_mag [2];
  logic [DATA_W+1:0]        pp [2];
  logic [DATA_W+1:0]        acc [2];
  logic [PRD_W-1:0]         sprod [2];
  logic signed [MAG_W-1:0]  term [2];
  logic signed [DATA_W-1:0] bnd [2];
  logic signed [DATA_W:0]   num [2];
  logic [DATA_W:0]          nmag [2];
  logic [MAG_W-1:0]         r0 [2];
  logic                     cond [2];
  logic [MAG_W:0]           trial [2];
  logic [MAG_W:0]           tdiff [2];
  logic                     ge [2];
  logic [BETA_W-1:0]        cand [2];
  logic [BETA_W-1:0]        beta_min;
  logic signed [DATA_W-1:0] fit_sat;
  logic                     res_load;

  assign in_probe.ready   = (state_r == ST_IDLE);
  assign out_result.valid = out_valid_r;
  assign out_result.data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      mean_r <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CENTER_X: cx_r   <= cfg_wdata;
        CFG_CENTER_Y: cy_r   <= cfg_wdata;
        CFG_MEAN:     mean_r <= cfg_wdata;
        CFG_SLOPE_X:  sx_r   <= cfg_wdata;
        CFG_SLOPE_Y:  sy_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // offsets from the cell center, clamped to 32 bits
  always_comb begin
    dx_wide = {in_probe.data.probe_x[DATA_W-1], in_probe.data.probe_x} -
              {cx_r[DATA_W-1], cx_r};
    dy_wide = {in_probe.data.probe_y[DATA_W-1], in_probe.data.probe_y} -
              {cy_r[DATA_W-1], cy_r};
    off_sat[0] = (dx_wide[DATA_W] == dx_wide[DATA_W-1]) ? dx_wide[DATA_W-1:0] :
                 (dx_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});
    off_sat[1] = (dy_wide[DATA_W] == dy_wide[DATA_W-1]) ? dy_wide[DATA_W-1:0] :
                 (dy_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});
    slope_mag[0] = sx_r[DATA_W-1] ? (~sx_r + 1'b1) : sx_r;
    slope_mag[1] = sy_r[DATA_W-1] ? (~sy_r + 1'b1) : sy_r;
    for (int i = 0; i < 2; i++) begin
      off_mag[i] = off_sat[i][DATA_W-1] ? (~off_sat[i] + 1'b1) : off_sat[i];
    end
  end

  // radix-4 multiply step, signed products, fit saturation
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      case (prod_r[i][1:0])
        2'd0:    pp[i] = '0;
        2'd1:    pp[i] = {2'b00, mcand_r[i]};
        2'd2:    pp[i] = {1'b0, mcand_r[i], 1'b0};
        default: pp[i] = {2'b00, mcand_r[i]} + {1'b0, mcand_r[i], 1'b0};
      endcase
      acc[i]   = {2'b00, prod_r[i][PRD_W-1:DATA_W]} + pp[i];
      sprod[i] = psign_r[i] ? (~prod_r[i] + 1'b1) : prod_r[i];
      // arithmetic shift right of the product is the floor division
      term[i]  = sprod[i][PRD_W-1:FRAC_BITS];
    end
    if (&z_r[Z_W-1:DATA_W-1] || ~|z_r[Z_W-1:DATA_W-1]) begin
      fit_sat = z_r[DATA_W-1:0];
    end else if (z_r[Z_W-1]) begin
      fit_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      fit_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // division setup and restoring step, per bound
  always_comb begin
    bnd[0]  = hi_r;
    bnd[1]  = lo_r;
    cond[0] = z_r > $signed({{(Z_W-DATA_W){hi_r[DATA_W-1]}}, hi_r});
    cond[1] = z_r < $signed({{(Z_W-DATA_W){lo_r[DATA_W-1]}}, lo_r});
    for (int i = 0; i < 2; i++) begin
      num[i]   = {bnd[i][DATA_W-1], bnd[i]} - {mean_r[DATA_W-1], mean_r};
      nmag[i]  = num[i][DATA_W] ? (~num[i] + 1'b1) : num[i];
      // quotient of (num << 16) / d reaches 2^17 exactly when (|num| >> 1) >= |d|
      r0[i]    = {{(MAG_W-DATA_W){1'b0}}, nmag[i][DATA_W:1]};
      trial[i] = {rem_r[i], sh_r[i][QUO_W-1]};
      tdiff[i] = trial[i] - {1'b0, dmag_r};
      ge[i]    = trial[i] >= {1'b0, dmag_r};
      if (!apply_r[i]) begin
        cand[i] = BETA_ONE;
      end else if (zero_r[i]) begin
        cand[i] = BETA_ZERO;
      end else if (ovf_r[i]) begin
        cand[i] = BETA_ONE;
      end else begin
        cand[i] = quo_r[i];
      end
    end
    beta_min = beta_r;
    if (cand[0] < beta_min) beta_min = cand[0];
    if (cand[1] < beta_min) beta_min = cand[1];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    beta_nxt      = beta_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    last_nxt      = last_r;
    d_nxt         = d_r;
    z_nxt         = z_r;
    dmag_nxt      = dmag_r;
    dnz_nxt       = dnz_r;
    res_load      = 1'b0;
    for (int i = 0; i < 2; i++) begin
      mcand_nxt[i] = mcand_r[i];
      prod_nxt[i]  = prod_r[i];
      psign_nxt[i] = psign_r[i];
      apply_nxt[i] = apply_r[i];
      zero_nxt[i]  = zero_r[i];
      ovf_nxt[i]   = ovf_r[i];
      rem_nxt[i]   = rem_r[i];
      sh_nxt[i]    = sh_r[i];
      quo_nxt[i]   = quo_r[i];
    end

    // drop the result once the sink takes it
    if (out_valid_r && out_result.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_probe.valid) begin
          lo_nxt   = in_probe.data.lower_bound;
          hi_nxt   = in_probe.data.upper_bound;
          last_nxt = in_probe.data.last_probe;
          for (int i = 0; i < 2; i++) begin
            mcand_nxt[i] = slope_mag[i];
            prod_nxt[i]  = {{DATA_W{1'b0}}, off_mag[i]};
          end
          psign_nxt[0] = sx_r[DATA_W-1] ^ off_sat[0][DATA_W-1];
          psign_nxt[1] = sy_r[DATA_W-1] ^ off_sat[1][DATA_W-1];
          cnt_nxt      = 5'(MUL_STEPS - 1);
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        for (int i = 0; i < 2; i++) begin
          prod_nxt[i] = {acc[i], prod_r[i][DATA_W-1:2]};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        d_nxt    = {term[0][MAG_W-1], term[0]} + {term[1][MAG_W-1], term[1]};
        z_nxt    = {{(Z_W-DATA_W){mean_r[DATA_W-1]}}, mean_r} + {d_nxt[D_W-1], d_nxt};
        dmag_nxt = d_nxt[D_W-1] ? MAG_W'(-d_nxt) : d_nxt[MAG_W-1:0];
        dnz_nxt  = (d_nxt != '0);
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        for (int i = 0; i < 2; i++) begin
          apply_nxt[i] = cond[i] && dnz_r;
          // quotient at or below zero clamps beta to zero
          zero_nxt[i]  = (num[i] == '0) || (num[i][DATA_W] != d_r[D_W-1]);
          ovf_nxt[i]   = r0[i] >= dmag_r;
          rem_nxt[i]   = r0[i];
          sh_nxt[i]    = {nmag[i][0], {(QUO_W-1){1'b0}}};
          quo_nxt[i]   = '0;
        end
        cnt_nxt   = 5'(QUO_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        for (int i = 0; i < 2; i++) begin
          rem_nxt[i] = ge[i] ? tdiff[i][MAG_W-1:0] : trial[i][MAG_W-1:0];
          sh_nxt[i]  = {sh_r[i][QUO_W-2:0], 1'b0};
          quo_nxt[i] = {quo_r[i][QUO_W-2:0], ge[i]};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_result.ready) begin
          res_load                  = 1'b1;
          out_valid_nxt             = 1'b1;
          out_data_nxt.fit_value    = fit_sat;
          out_data_nxt.limit_factor = beta_min;
          out_data_nxt.final_res    = last_r;
          beta_nxt  = last_r ? BETA_ONE : beta_min;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      beta_r      <= BETA_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      beta_r      <= beta_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    last_r     <= last_nxt;
    d_r        <= d_nxt;
    z_r        <= z_nxt;
    dmag_r     <= dmag_nxt;
    dnz_r      <= dnz_nxt;
    for (int i = 0; i < 2; i++) begin
      mcand_r[i] <= mcand_nxt[i];
      prod_r[i]  <= prod_nxt[i];
      psign_r[i] <= psign_nxt[i];
      apply_r[i] <= apply_nxt[i];
      zero_r[i]  <= zero_nxt[i];
      ovf_r[i]   <= ovf_nxt[i];
      rem_r[i]   <= rem_nxt[i];
      sh_r[i]    <= sh_nxt[i];
      quo_r[i]   <= quo_nxt[i];
    end
  end

  // running beta never leaves the range zero to one
  assert property (@(posedge clk) disable iff (!rst_n) beta_r <= BETA_ONE)
    else $error("running beta above one");

  // a finished set puts beta back to one
  assert property (@(posedge clk) disable iff (!rst_n)
    res_load && last_r |=> beta_r == BETA_ONE)
    else $error("beta not restored after final probe");

  // a reported factor never exceeds the beta it started from
  assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_data_nxt.limit_factor <= beta_r)
    else $error("limit factor raised beta");

  // the upper-bound divider keeps its remainder below the divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && dnz_r && !ovf_r[0] |-> rem_r[0] < dmag_r)
    else $error("divider remainder out of range");

  // a taken probe always starts the multiply phase
  assert property (@(posedge clk) disable iff (!rst_n)
    in_probe.valid && in_probe.ready |=> state_r == ST_MUL)
    else $error("probe transfer did not start multiply");

endmodule

`default_nettype wire

/* bench/gsl_limit_checker.sv */
// Scoreboard for the gradient slope limiter core: mirrors register writes,
// predicts one result per probe transfer and compares result transfers.
// Depends on gsl_pkg and the channel interfaces in gsl_if.sv.
`default_nettype none

module gsl_limit_checker
  import gsl_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  gsl_probe_if                probe_ch,
  gsl_result_if               result_ch,
  input  wire                 cfg_wr_en,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [DATA_W-1:0]    cfg_wdata,
  output int                  fail_count,
  output int                  results_owed,
  output int                  results_seen,
  output int                  cells_closed,
  output int                  cells_limited
);

  localparam longint WORD_MAX   = 64'sd2147483647;
  localparam longint WORD_MIN   = -64'sd2147483648;
  localparam longint BETA_SCALE = 64'sd65536;

  // mirrored fit registers and running factor
  longint fit_cx, fit_cy, fit_mean, fit_sx, fit_sy;
  longint beta_now;
  result_t owed_q[$];
  int fails, seen, closed, limited;

  function automatic longint sat_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint cut_beta(input longint excess, input longint slope_term,
                                      input longint beta);
    longint q;
    q = (excess * BETA_SCALE) / slope_term;
    if (q < 0) return 0;
    if (q < beta) return q;
    return beta;
  endfunction

  // expected result for one probe; advances the running factor
  function automatic result_t limit_probe(input probe_t p);
    longint dx, dy, term, fit, beta, lo, hi, fit_sat;
    result_t r;
    lo = longint'(p.lower_bound);
    hi = longint'(p.upper_bound);
    dx = sat_word(longint'(p.probe_x) - fit_cx);
    dy = sat_word(longint'(p.probe_y) - fit_cy);
    term = ((fit_sx * dx) >>> FRAC_BITS) + ((fit_sy * dy) >>> FRAC_BITS);
    fit = fit_mean + term;
    beta = beta_now;
    if (term != 0 && fit > hi) beta = cut_beta(hi - fit_mean, term, beta);
    if (term != 0 && fit < lo) beta = cut_beta(lo - fit_mean, term, beta);
    if (beta < 0) beta = 0;
    if (beta > BETA_SCALE) beta = BETA_SCALE;
    fit_sat = sat_word(fit);
    r.fit_value    = fit_sat[DATA_W-1:0];
    r.limit_factor = beta[BETA_W-1:0];
    r.final_res    = p.last_probe;
    beta_now = p.last_probe ? BETA_SCALE : beta;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want, got;
    if (!rst_n) begin
      owed_q.delete();
      fit_cx = 0; fit_cy = 0; fit_mean = 0; fit_sx = 0; fit_sy = 0;
      beta_now = BETA_SCALE;
      fails = 0; seen = 0; closed = 0; limited = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CENTER_X: fit_cx   = longint'($signed(cfg_wdata));
          CFG_CENTER_Y: fit_cy   = longint'($signed(cfg_wdata));
          CFG_MEAN:     fit_mean = longint'($signed(cfg_wdata));
          CFG_SLOPE_X:  fit_sx   = longint'($signed(cfg_wdata));
          CFG_SLOPE_Y:  fit_sy   = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (probe_ch.valid && probe_ch.ready)
        owed_q.push_back(limit_probe(probe_ch.data));
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (owed_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result fit %0d beta %0d final %0b, nothing owed",
                   $time, $signed(got.fit_value), got.limit_factor, got.final_res);
        end else begin
          want = owed_q.pop_front();
          if (got.fit_value !== want.fit_value || got.limit_factor !== want.limit_factor ||
              got.final_res !== want.final_res) begin
            fails++;
            $display("%0t: result %0d expected fit %0d beta %0d final %0b, got fit %0d beta %0d final %0b",
                     $time, seen, $signed(want.fit_value), want.limit_factor, want.final_res,
                     $signed(got.fit_value), got.limit_factor, got.final_res);
          end
          if (want.final_res) begin
            closed++;
            if (want.limit_factor < BETA_ONE) limited++;
          end
        end
        seen++;
      end
    end
    fail_count    <= fails;
    results_owed  <= owed_q.size();
    results_seen  <= seen;
    cells_closed  <= closed;
    cells_limited <= limited;
  end

endmodule

`default_nettype wire

/* bench/tb_gradient_slope_limiter_core.sv */
// Top-level bench for the gradient slope limiter core: drives probe items,
// fit registers and result back-pressure; gsl_limit_checker does the checking.
// Depends on gsl_pkg, gsl_if.sv, the core and bench/gsl_limit_checker.sv.
`default_nettype none

module tb_gradient_slope_limiter_core;
  import gsl_pkg::*;

  localparam int FRAC_BITS         = 16;
  localparam int CLK_HALF          = 6;
  localparam int WATCHDOG_CYCLES   = 600000;
  localparam int DRAIN_CYCLES      = 48;
  localparam int HOLD_CYCLES       = 320;
  localparam int CONFIGS_PER_MODE  = 5;
  localparam int PROBES_PER_CONFIG = 50;

  // traffic mixes: free flow, sender idling, receiver stalling, both
  localparam int IDLE_BY_MODE  [4] = '{0, 54, 0, 36};
  localparam int STALL_BY_MODE [4] = '{0, 0, 54, 36};

  localparam logic signed [31:0] WMAX  = 32'sh7fffffff;
  localparam logic signed [31:0] WMIN  = 32'sh80000000;
  localparam logic signed [31:0] ONE_Q = 32'sh00010000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int fit_settings  = 0;

  // current fit, kept so random probes land near the cell
  logic signed [31:0] cur_cx = '0, cur_cy = '0, cur_mean = '0;

  int fail_count, results_owed, results_seen, cells_closed, cells_limited;

  gsl_probe_if  probe_ch ();
  gsl_result_if result_ch ();

  gradient_slope_limiter_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_probe   (probe_ch),
    .out_result (result_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  gsl_limit_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .probe_ch      (probe_ch),
    .result_ch     (result_ch),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .results_owed  (results_owed),
    .results_seen  (results_seen),
    .cells_closed  (cells_closed),
    .cells_limited (cells_limited)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog: far beyond the slowest legal run, including every long hold.
  initial begin
    #(2 * CLK_HALF * WATCHDOG_CYCLES);
    $display("%0t: timeout, %0d results still owed", $time, results_owed);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stalls per the current mix; on each new hold request
  // keep ready low for HOLD_CYCLES so the core fills up and blocks its input.
  initial begin : result_sink
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic probe_t probe_at(input logic signed [31:0] px, py, lo, hi,
                                      input logic last);
    probe_t p;
    p.probe_x     = px;
    p.probe_y     = py;
    p.lower_bound = lo;
    p.upper_bound = hi;
    p.last_probe  = last;
    return p;
  endfunction

  // uniform in [-span, span]
  function automatic logic signed [31:0] near(input int span);
    return int'($urandom_range(2 * span, 0)) - span;
  endfunction

  // full-range word, biased toward the corners
  function automatic logic signed [31:0] any_word();
    case ($urandom_range(5))
      0:       return WMAX;
      1:       return WMIN;
      2:       return '0;
      3:       return -1;
      default: return $urandom();
    endcase
  endfunction

  // well-formed probe: close to the cell centre, bounds around the mean,
  // now and then crossed so that both bounds are missed
  function automatic probe_t shaped_probe(input logic last);
    logic signed [31:0] lo, hi, t;
    lo = cur_mean - $urandom_range(1 << 18, 0);
    hi = cur_mean + $urandom_range(1 << 18, 0);
    if ($urandom_range(19) == 0) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    return probe_at(cur_cx + near(1 << 18), cur_cy + near(1 << 18), lo, hi, last);
  endfunction

  // Present one register write; the caller drops cfg_wr_en after the last.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic signed [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_fit(input logic signed [31:0] cx, cy, mean, sx, sy);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_MEAN, mean);
    write_reg(CFG_SLOPE_X, sx);
    write_reg(CFG_SLOPE_Y, sy);
    cfg_wr_en <= 1'b0;
    cur_cx   = cx;
    cur_cy   = cy;
    cur_mean = mean;
    fit_settings++;
  endtask

  // Mostly moderate fits that give fractional factors; some corner fits.
  task automatic load_random_fit();
    int kind;
    kind = $urandom_range(9);
    if (kind == 0)
      load_fit(any_word(), any_word(), any_word(), any_word(), any_word());
    else if (kind == 1)
      load_fit($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    else
      load_fit(near(1 << 20), near(1 << 20), near(1 << 22),
               ($urandom_range(5) == 0) ? '0 : near(1 << 19),
               ($urandom_range(5) == 0) ? '0 : near(1 << 19));
  endtask

  // Offer one probe and hold it until the transfer. Idle first per the mix;
  // valid is only lowered when a gap is actually inserted.
  task automatic send_probe(input probe_t p);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0 && $urandom_range(7) == 0) gap += $urandom_range(50, 1);
    if (gap > 0) begin
      probe_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    probe_ch.valid <= 1'b1;
    probe_ch.data  <= p;
    do @(posedge clk); while (!probe_ch.ready);
  endtask

  // Drop valid, then wait until every owed result has been taken. The first
  // edge lets the owed count catch up with the final transfer.
  task automatic wait_drained();
    probe_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Cells of random length; about one probe in five is full-range noise.
  task automatic send_cells(input int count);
    int left, len;
    probe_t p;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(12, 1) : $urandom_range(5, 1);
      for (int k = 0; k < len && left > 0; k++) begin
        if ($urandom_range(4) == 0)
          p = probe_at(any_word(), any_word(), any_word(), any_word(),
                       1'($urandom_range(1)));
        else
          p = shaped_probe(k == len - 1 || left == 1);
        send_probe(p);
        left--;
      end
    end
  endtask

  initial begin
    probe_ch.valid = 1'b0;
    probe_ch.data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fit still at reset: zero slope term never lowers the factor, even with
    // crossed bounds that the fit misses on both sides.
    send_probe(probe_at(WMAX, WMIN, ONE_Q, -ONE_Q, 1'b1));
    wait_drained();

    // Fit 0.5 + 2*(x-1) - (y+2): inside, above, already-lower quotient,
    // below, both bounds missed, negative quotient, fit on the bound,
    // truncated quotients for either sign of the slope term.
    load_fit(ONE_Q, -2 * ONE_Q, ONE_Q / 2, 2 * ONE_Q, -ONE_Q);
    send_probe(probe_at(2 * ONE_Q, -2 * ONE_Q, '0, 3 * ONE_Q, 1'b0));
    send_probe(probe_at(3 * ONE_Q, -2 * ONE_Q, '0, ONE_Q * 5 / 2, 1'b0));
    send_probe(probe_at(2 * ONE_Q, -2 * ONE_Q, '0, 2 * ONE_Q, 1'b0));
    send_probe(probe_at('0, -2 * ONE_Q, -ONE_Q / 4, 3 * ONE_Q, 1'b1));
    send_probe(probe_at(3 * ONE_Q, -2 * ONE_Q, 5 * ONE_Q, 4 * ONE_Q, 1'b0));
    send_probe(probe_at(3 * ONE_Q, -2 * ONE_Q, -ONE_Q, '0, 1'b1));
    send_probe(probe_at(2 * ONE_Q, -2 * ONE_Q, ONE_Q * 5 / 2, ONE_Q * 5 / 2, 1'b1));
    send_probe(probe_at(ONE_Q + 3, -2 * ONE_Q, -ONE_Q, ONE_Q / 2 + 1, 1'b1));
    send_probe(probe_at(ONE_Q - 3, -2 * ONE_Q, ONE_Q / 2 - 1, ONE_Q, 1'b0));
    send_probe(probe_at(ONE_Q, -2 * ONE_Q + 5, ONE_Q / 2 - 2, ONE_Q, 1'b1));
    wait_drained();

    // Corner fits: offsets and fit saturate, huge slope terms.
    load_fit(WMIN, WMAX, WMAX, WMIN, WMAX);
    send_probe(probe_at(WMAX, WMIN, WMIN, WMAX, 1'b0));
    send_probe(probe_at(WMIN, WMAX, WMIN, WMAX, 1'b1));
    send_probe(probe_at(-1, -1, '0, -1, 1'b1));
    wait_drained();
    load_fit('0, '0, WMIN, WMAX, WMAX);
    send_probe(probe_at(WMAX, WMAX, WMIN, WMIN, 1'b0));
    send_probe(probe_at(WMIN, WMIN, WMIN, WMAX, 1'b1));
    send_probe(probe_at('0, '0, '0, '0, 1'b0));
    send_probe(probe_at(-1, WMAX, WMAX, WMIN, 1'b1));

    // Random part: each mix runs through several fits. On the second fit of
    // each mix hold the receiver off while probes keep coming; on the third,
    // pause the sender mid-stream until everything owed has come back.
    for (int m = 0; m < 4; m++) begin
      wait_drained();
      idle_pct  = IDLE_BY_MODE[m];
      stall_pct = STALL_BY_MODE[m];
      for (int c = 0; c < CONFIGS_PER_MODE; c++) begin
        wait_drained();
        load_random_fit();
        if (c == 1) hold_requests++;
        if (c == 2) begin
          send_cells(PROBES_PER_CONFIG / 2);
          wait_drained();
          send_cells(PROBES_PER_CONFIG - PROBES_PER_CONFIG / 2);
        end else begin
          send_cells(PROBES_PER_CONFIG);
        end
      end
    end

    // Drain, then give a stray late result time to show up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results over %0d fit settings and four traffic mixes;",
             results_seen, fit_settings);
    $display("%0d cells closed, %0d of them with the factor limited below one.",
             cells_closed, cells_limited);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
